/* src/ofq_pkg.sv */
// Shared types and constants for the ordered-or-FIFO queue.
`timescale 1ns / 1ps
package ofq_pkg;

  localparam int KEY_W   = 32;
  localparam int HDL_W   = 32;
  localparam int CNT_W   = 6;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = KEY_W + HDL_W;

  localparam logic [ADDR_W-3:0] REG_ORDERED_MODE = '0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INSERT,
    S_HEAD,
    S_REPLY
  } state_t;

  typedef struct packed {
    command_t           command;
    logic [KEY_W-1:0]   item_key;
    logic [HDL_W-1:0]   item_handle;
  } req_beat_t;

  typedef struct packed {
    status_t            status;
    logic [HDL_W-1:0]   head_handle;
    logic [KEY_W-1:0]   head_key;
    logic [CNT_W-1:0]   entry_count;
  } rsp_beat_t;

  typedef struct packed {
    logic    load_item;
    logic    ins_start;
    logic    ins_step;
    logic    rd_head;
    logic    pop_head;
    logic    clear;
    logic    res_set;
    logic    res_head;
    status_t res_status;
    logic    load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    command_t command;
    logic     full;
    logic     empty;
    logic     ins_done;
    logic     out_free;
  } dp_stat_t;

endpackage

/* src/ordered_or_fifo_queue.sv */
// Top level of the ordered-or-FIFO queue with its register port.
//
//  channel  | handshake          | beat
//  ---------+--------------------+-----------------------------------------
//  request  | req_valid/ready    | command, item_key, item_handle
//  response | rsp_valid/ready    | status, head_handle, head_key, entry_count
//  config   | psel/penable/pready| ordered_mode at byte address 0
//
// One command at a time: accept, decode, work, reply. Clear and a full or empty
// reply go straight from decode to reply; in an ordered insert the single RAM
// read port walks the held entries once.
// A new request is taken while the last response still waits for rsp_ready.
// rst is synchronous; the entry RAM needs no clearing after reset.
`timescale 1ns / 1ps
module ordered_or_fifo_queue #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ofq_pkg::req_beat_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output ofq_pkg::rsp_beat_t          rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ofq_pkg::ADDR_W-1:0]  paddr,
  input  logic [ofq_pkg::DATA_W-1:0]  pwdata,
  output logic [ofq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ofq_pkg::*;

  logic      ordered_mode;
  logic      reg_hit;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_ORDERED_MODE);
  assign prdata  = reg_hit ? {{(DATA_W - 1){1'b0}}, ordered_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ordered_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      ordered_mode <= pwdata[0];
    end
  end

  ofq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ofq_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ordered_mode(ordered_mode),
    .req         (req),
    .cmd         (cmd),
    .stat        (stat),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

endmodule

/* src/ofq_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ofq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ofq_datapath.sv */
// Queue storage, pointers, insert shifter and result register.
`timescale 1ns / 1ps
module ofq_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ordered_mode,
  input  ofq_pkg::req_beat_t  req,
  input  ofq_pkg::ctrl_cmd_t  cmd,
  output ofq_pkg::dp_stat_t   stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ofq_pkg::rsp_beat_t  rsp
);
  import ofq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  req_beat_t          item;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [AW-1:0]      rd_ptr;
  logic [AW-1:0]      wr_ptr;
  logic [CW-1:0]      rd_left;
  logic               s1_valid;
  logic               found;
  logic [ENTRY_W-1:0] carry;
  status_t            res_status;
  logic [KEY_W-1:0]   res_key;
  logic [HDL_W-1:0]   res_handle;

  logic [AW:0]        tail_sum;
  logic [AW-1:0]      tail;
  logic               issue;
  logic               shift_wr;
  logic               final_wr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] new_entry;
  logic               greater;

  assign tail_sum  = {1'b0, head} + (AW + 1)'(count);
  assign tail      = (tail_sum >= (AW + 1)'(CAPACITY)) ? AW'(tail_sum - (AW + 1)'(CAPACITY))
                                                       : AW'(tail_sum);
  assign new_entry = {item.item_key, item.item_handle};
  assign greater   = ram_rdata[ENTRY_W-1 -: KEY_W] > item.item_key;

  assign issue     = cmd.ins_step && (rd_left != '0);
  assign shift_wr  = cmd.ins_step && s1_valid && (found || greater);
  assign final_wr  = cmd.ins_step && stat.ins_done;

  assign ram_we    = shift_wr || final_wr;
  assign ram_waddr = wr_ptr;
  assign ram_wdata = found ? carry : new_entry;
  assign ram_re    = issue || cmd.rd_head;
  assign ram_raddr = cmd.rd_head ? head : rd_ptr;

  assign stat.command  = item.command;
  assign stat.full     = (count == CW'(CAPACITY));
  assign stat.empty    = (count == '0);
  assign stat.ins_done = (rd_left == '0) && !s1_valid;
  assign stat.out_free = !rsp_valid || rsp_ready;

  ofq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rd_left   <= '0;
      s1_valid  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.ins_start) begin
        rd_ptr   <= head;
        wr_ptr   <= ordered_mode ? head : tail;
        rd_left  <= ordered_mode ? count : '0;
        s1_valid <= 1'b0;
        found    <= 1'b0;
      end else if (cmd.ins_step) begin
        s1_valid <= issue;
        if (issue) begin
          rd_ptr  <= ptr_inc(rd_ptr);
          rd_left <= rd_left - 1'b1;
        end
        if (s1_valid) begin
          wr_ptr <= ptr_inc(wr_ptr);
          if (found || greater) begin
            found <= 1'b1;
            carry <= ram_rdata;
          end
        end
        if (final_wr) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.pop_head) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.load_result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_key    <= cmd.res_head ? ram_rdata[ENTRY_W-1 -: KEY_W] : '0;
      res_handle <= cmd.res_head ? ram_rdata[HDL_W-1:0] : '0;
    end
    if (cmd.load_result) begin
      rsp.status      <= res_status;
      rsp.head_handle <= res_handle;
      rsp.head_key    <= res_key;
      rsp.entry_count <= CNT_W'(count);
    end
  end

endmodule

/* src/ofq_controller.sv */
// Command sequencer for the ordered-or-FIFO queue.
`timescale 1ns / 1ps
module ofq_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ofq_pkg::dp_stat_t  stat,
  output ofq_pkg::ctrl_cmd_t cmd
);
  import ofq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_OK;
    req_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.command)
          CMD_INSERT: begin
            if (stat.full) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_REPLY;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_INSERT;
            end
          end
          CMD_REMOVE, CMD_PEEK: begin
            if (stat.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_REPLY;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_HEAD;
            end
          end
          CMD_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.res_set = 1'b1;
            state_next  = S_REPLY;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INSERT: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_done) begin
          cmd.res_set = 1'b1;
          state_next  = S_REPLY;
        end
      end
      S_HEAD: begin
        cmd.res_set  = 1'b1;
        cmd.res_head = 1'b1;
        cmd.pop_head = (stat.command == CMD_REMOVE);
        state_next   = S_REPLY;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/ofq_checker.sv */
// Port-level checks for the ordered-or-FIFO queue, bound to the top level.
`timescale 1ns / 1ps
module ofq_checker #(
  parameter int CAPACITY = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input ofq_pkg::rsp_beat_t rsp
);
  import ofq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat dropped or changed while stalled");

  a_no_head_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.head_key == '0) && (rsp.head_handle == '0))
    else $error("error response carries head fields");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.entry_count == CNT_W'(CAPACITY))
    else $error("full response with wrong count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.entry_count == '0)
    else $error("empty response with nonzero count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 63) || (rsp.entry_count <= CNT_W'(CAPACITY)))
    else $error("response count above capacity");

endmodule

bind ordered_or_fifo_queue ofq_checker #(
  .CAPACITY(CAPACITY)
) u_ofq_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);
